>>> rtl/core/cpt_pkg.sv
// Shared types and codes for the closest-point-on-triangle unit.
package cpt_pkg;

  // Region codes reported with every result.
  typedef logic [2:0] region_t;
  localparam region_t REG_A   = 3'd0;
  localparam region_t REG_B   = 3'd1;
  localparam region_t REG_C   = 3'd2;
  localparam region_t REG_AB  = 3'd3;
  localparam region_t REG_AC  = 3'd4;
  localparam region_t REG_BC  = 3'd5;
  localparam region_t REG_INT = 3'd6;

  // Stage control handed to each pipelined arithmetic unit.
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

>>> rtl/core/cpt_if.sv
// Valid/ready channel interfaces for the query and result transactions.
interface cpt_in_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] vert_a_x;
  logic signed [COORD_BITS-1:0] vert_a_y;
  logic signed [COORD_BITS-1:0] vert_a_z;
  logic signed [COORD_BITS-1:0] vert_b_x;
  logic signed [COORD_BITS-1:0] vert_b_y;
  logic signed [COORD_BITS-1:0] vert_b_z;
  logic signed [COORD_BITS-1:0] vert_c_x;
  logic signed [COORD_BITS-1:0] vert_c_y;
  logic signed [COORD_BITS-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

interface cpt_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] near_x;
  logic signed [COORD_BITS-1:0] near_y;
  logic signed [COORD_BITS-1:0] near_z;
  logic [2:0]                   region;
  logic                         degenerate;

  modport source (
    output valid, near_x, near_y, near_z, region, degenerate,
    input  ready
  );
  modport sink (
    input  valid, near_x, near_y, near_z, region, degenerate,
    output ready
  );
endinterface

>>> rtl/core/cpt_mul.sv
// Pipelined signed multiplier that consumes one digit of the second operand per stage.
module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int TW = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpt_pkg::pipe_ctl_t        ctl_i,
  input  logic signed [AW-1:0]      a_i,
  input  logic signed [BW-1:0]      b_i,
  input  logic [TW-1:0]             tag_i,
  output logic                      vld_o,
  output logic signed [AW+BW-1:0]   prod_o,
  output logic [TW-1:0]             tag_o
);
  import cpt_pkg::*;

  // Digit width keeps each partial product near 32 by 32 bits.
  localparam int DIG0 = 1024 / AW;
  localparam int DIG  = (DIG0 < 1) ? 1 : ((DIG0 > BW) ? BW : DIG0);
  localparam int NST  = (BW + DIG - 1) / DIG;
  localparam int BP   = NST * DIG;
  localparam int PWF  = AW + BP;

  logic                   vld_r [NST];
  logic signed [AW-1:0]   a_r   [NST];
  logic signed [BP-1:0]   b_r   [NST];
  logic signed [PWF-1:0]  acc_r [NST];
  logic [TW-1:0]          tag_r [NST];
  logic signed [BP-1:0]   b_ext;

  assign b_ext = BP'(b_i);

  // One partial product is added to the running sum in each stage.
  for (genvar k = 0; k < NST; k++) begin : g_st
    logic                   vld_in;
    logic signed [AW-1:0]   a_in;
    logic signed [BP-1:0]   b_in;
    logic signed [PWF-1:0]  acc_in;
    logic [TW-1:0]          tag_in;
    logic signed [DIG:0]    dig;
    logic signed [AW+DIG:0] part;
    logic signed [PWF-1:0]  part_ext;
    logic signed [PWF-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign vld_in = ctl_i.vld;
      assign a_in   = a_i;
      assign b_in   = b_ext;
      assign acc_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    // The top digit carries the sign of the second operand.
    assign dig      = {(k == NST - 1) ? b_in[k*DIG+DIG-1] : 1'b0, b_in[k*DIG +: DIG]};
    assign part     = a_in * dig;
    assign part_ext = PWF'(part);
    assign acc_nxt  = acc_in + (part_ext <<< (k * DIG));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        a_r[k]   <= a_in;
        b_r[k]   <= b_in;
        acc_r[k] <= acc_nxt;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign vld_o  = vld_r[NST-1];
  assign prod_o = acc_r[NST-1][AW+BW-1:0];
  assign tag_o  = tag_r[NST-1];

endmodule

>>> rtl/core/cpt_div.sv
// Pipelined restoring divider giving round-half-up of a signed numerator over a positive divisor.
module cpt_div #(
  parameter int NW = 173,
  parameter int DW = 139,
  parameter int QB = 35,
  parameter int TW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpt_pkg::pipe_ctl_t   ctl_i,
  input  logic signed [NW-1:0] num_i,
  input  logic [DW-1:0]        den_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 vld_o,
  output logic signed [QB:0]   quo_o,
  output logic [TW-1:0]        tag_o
);
  import cpt_pkg::*;

  localparam int W0 = NW + 2;
  localparam int W1 = DW + 1 + QB;
  localparam int W  = (W0 > W1) ? W0 : W1;

  // Pre-stage: round(n/d) = floor((2n + d) / 2d); a negative dividend is folded by inversion.
  logic signed [W-1:0] n2;
  logic                pre_vld_r;
  logic [W-1:0]        pre_m_r;
  logic [W-1:0]        pre_d2_r;
  logic                pre_sgn_r;
  logic [TW-1:0]       pre_tag_r;

  assign n2 = (W'(num_i) <<< 1) + W'(den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      pre_vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      pre_m_r   <= n2 ^ {W{n2[W-1]}};
      pre_d2_r  <= W'(den_i) << 1;
      pre_sgn_r <= n2[W-1];
      pre_tag_r <= tag_i;
    end
  end

  logic          vld_r [QB];
  logic [W-1:0]  rem_r [QB];
  logic [W-1:0]  dv_r  [QB];
  logic [QB-1:0] quo_r [QB];
  logic          sgn_r [QB];
  logic [TW-1:0] tag_r [QB];

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < QB; s++) begin : g_st
    logic          vld_in;
    logic [W-1:0]  rem_in;
    logic [W-1:0]  dv_in;
    logic [QB-1:0] quo_in;
    logic          sgn_in;
    logic [TW-1:0] tag_in;
    logic [W:0]    trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_in = pre_vld_r;
      assign rem_in = pre_m_r;
      assign dv_in  = pre_d2_r;
      assign quo_in = '0;
      assign sgn_in = pre_sgn_r;
      assign tag_in = pre_tag_r;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign dv_in  = dv_r[s-1];
      assign quo_in = quo_r[s-1];
      assign sgn_in = sgn_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    assign trial = {1'b0, rem_in} - {1'b0, dv_in << (QB - 1 - s)};
    assign ge    = !trial[W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        rem_r[s] <= ge ? trial[W-1:0] : rem_in;
        dv_r[s]  <= dv_in;
        quo_r[s] <= {quo_in[QB-2:0], ge};
        sgn_r[s] <= sgn_in;
        tag_r[s] <= tag_in;
      end
    end
  end

  // Unfold the sign: floor of a negative dividend is the inverse of the folded quotient.
  assign vld_o = vld_r[QB-1];
  assign quo_o = {1'b0, quo_r[QB-1]} ^ {(QB + 1){sgn_r[QB-1]}};
  assign tag_o = tag_r[QB-1];

endmodule

>>> rtl/core/cpt_obuf.sv
// Two-entry output buffer that parts the pipeline from the result receiver.
module cpt_obuf #(
  parameter int DW = 100
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o
);
  logic [1:0]    cnt_r;
  logic          wr_r;
  logic          rd_r;
  logic [DW-1:0] mem_r [2];
  logic          pop;

  assign valid_o = (cnt_r != 2'd0);
  assign ready_o = (cnt_r != 2'd2);
  assign pop     = valid_o && pop_i;
  assign data_o  = mem_r[rd_r];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      if (push_i) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= data_i;
    end
  end

endmodule

>>> rtl/core/closest_point_on_triangle_unit.sv
// Top level of the closest-point-on-triangle unit.
//
// Each in_chan transaction carries a query point P and triangle vertices A, B, C as
// signed fixed-point coordinates. Each out_chan transaction returns the nearest point
// on the triangle, the region code (vertex A/B/C, edge AB/AC/BC or interior) and a
// degenerate flag, raised when the interior denominator is not positive; near is then A.
// Both channels use valid/ready; a transaction moves when both are high.
// One transaction is accepted per cycle while in_chan.ready is high. A query passes
// through the difference, dot-product, cross-term, region and numerator stages, a
// sign-folding stage and COORD_BITS + 3 quotient-bit stages in the rounding divider,
// then the output buffer.
// All region tests use exact integer products, so each region decision is exact.
// Reset clears every valid bit and empties the output buffer; no transaction is in flight.
// When the receiver stalls, the two-entry output buffer keeps accepting until it is full,
// after which in_chan.ready drops and the whole pipeline holds its contents.
module closest_point_on_triangle_unit #(
  parameter int COORD_BITS = 32
) (
  input logic    clk,
  input logic    rst_n,
  cpt_in_if.sink   in_chan,
  cpt_out_if.source out_chan
);
  import cpt_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DFW = CB + 1;
  localparam int PW  = 2 * DFW + 2;
  localparam int VW  = 2 * PW + 1;
  localparam int FW  = VW + 2;
  localparam int NMW = FW + DFW + 1;
  localparam int QB  = CB + 3;
  localparam int SW  = QB + 3;

  typedef struct packed {
    logic [2:0][CB-1:0]  a;
    logic [2:0][CB-1:0]  b;
    logic [2:0][CB-1:0]  c;
    logic [2:0][DFW-1:0] ab;
    logic [2:0][DFW-1:0] ac;
    logic [2:0][DFW-1:0] bc;
  } side_t;

  typedef struct packed {
    logic [5:0][PW-1:0] d;
    side_t              side;
  } vside_t;

  typedef struct packed {
    logic [FW-1:0]      den;
    logic [2:0][CB-1:0] base;
    region_t            region;
    logic               degen;
  } nside_t;

  typedef struct packed {
    logic [2:0][CB-1:0] base;
    region_t            region;
    logic               degen;
  } oside_t;

  typedef struct packed {
    logic [2:0][CB-1:0] near;
    region_t            region;
    logic               degen;
  } out_t;

  typedef enum logic [1:0] {BASE_A, BASE_B, BASE_C} base_sel_t;
  typedef enum logic [1:0] {VEC_AB, VEC_AC, VEC_BC} vec_sel_t;

  logic en;

  // Stage 1: edge and offset vectors.
  logic signed [CB-1:0]  pin [3];
  logic signed [CB-1:0]  ain [3];
  logic signed [CB-1:0]  bin [3];
  logic signed [CB-1:0]  cin [3];
  logic                  s1_vld_r;
  logic signed [CB-1:0]  a_r  [3];
  logic signed [CB-1:0]  b_r  [3];
  logic signed [CB-1:0]  c_r  [3];
  logic signed [DFW-1:0] ab_r [3];
  logic signed [DFW-1:0] ac_r [3];
  logic signed [DFW-1:0] bc_r [3];
  logic signed [DFW-1:0] ap_r [3];
  logic signed [DFW-1:0] bp_r [3];
  logic signed [DFW-1:0] cp_r [3];

  assign in_chan.ready = en;
  assign pin[0] = in_chan.point_x;
  assign pin[1] = in_chan.point_y;
  assign pin[2] = in_chan.point_z;
  assign ain[0] = in_chan.vert_a_x;
  assign ain[1] = in_chan.vert_a_y;
  assign ain[2] = in_chan.vert_a_z;
  assign bin[0] = in_chan.vert_b_x;
  assign bin[1] = in_chan.vert_b_y;
  assign bin[2] = in_chan.vert_b_z;
  assign cin[0] = in_chan.vert_c_x;
  assign cin[1] = in_chan.vert_c_y;
  assign cin[2] = in_chan.vert_c_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i]  <= ain[i];
        b_r[i]  <= bin[i];
        c_r[i]  <= cin[i];
        ab_r[i] <= DFW'(bin[i]) - DFW'(ain[i]);
        ac_r[i] <= DFW'(cin[i]) - DFW'(ain[i]);
        bc_r[i] <= DFW'(cin[i]) - DFW'(bin[i]);
        ap_r[i] <= DFW'(pin[i]) - DFW'(ain[i]);
        bp_r[i] <= DFW'(pin[i]) - DFW'(bin[i]);
        cp_r[i] <= DFW'(pin[i]) - DFW'(cin[i]);
      end
    end
  end

  // Dot products d1..d6: AB.AP, AC.AP, AB.BP, AC.BP, AB.CP, AC.CP, one product per lane.
  side_t                   side1;
  side_t                   side_dm;
  logic                    dm_vld;
  logic signed [2*DFW-1:0] dp [6][3];
  pipe_ctl_t               ctl_dot;

  assign ctl_dot = '{en: en, vld: s1_vld_r};

  for (genvar i = 0; i < 3; i++) begin : g_side
    assign side1.a[i]  = a_r[i];
    assign side1.b[i]  = b_r[i];
    assign side1.c[i]  = c_r[i];
    assign side1.ab[i] = ab_r[i];
    assign side1.ac[i] = ac_r[i];
    assign side1.bc[i] = bc_r[i];
  end

  for (genvar j = 0; j < 6; j++) begin : g_dj
    for (genvar i = 0; i < 3; i++) begin : g_di
      logic signed [DFW-1:0] lhs;
      logic signed [DFW-1:0] rhs;
      assign lhs = (j % 2 == 0) ? ab_r[i] : ac_r[i];
      assign rhs = (j / 2 == 0) ? ap_r[i] : ((j / 2 == 1) ? bp_r[i] : cp_r[i]);
      if (j == 0 && i == 0) begin : g_tag
        cpt_mul #(.AW(DFW), .BW(DFW), .TW($bits(side_t))) u_mul (
          .clk(clk), .rst_n(rst_n), .ctl_i(ctl_dot), .a_i(lhs), .b_i(rhs),
          .tag_i(side1), .vld_o(dm_vld), .prod_o(dp[j][i]), .tag_o(side_dm)
        );
      end else begin : g_plain
        cpt_mul #(.AW(DFW), .BW(DFW), .TW(1)) u_mul (
          .clk(clk), .rst_n(rst_n), .ctl_i(ctl_dot), .a_i(lhs), .b_i(rhs),
          .tag_i(1'b0), .vld_o(), .prod_o(dp[j][i]), .tag_o()
        );
      end
    end
  end

  // Sum the three lanes of each dot product.
  logic                 d_vld_r;
  logic signed [PW-1:0] d_r [6];
  side_t                side_d_r;
  vside_t               vside1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= dm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        d_r[j] <= PW'(dp[j][0]) + PW'(dp[j][1]) + PW'(dp[j][2]);
      end
      side_d_r <= side_dm;
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_vd
    assign vside1.d[j] = d_r[j];
  end
  assign vside1.side = side_d_r;

  // Cross terms: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  localparam int RHS_IDX [6] = '{3, 1, 1, 5, 5, 3};
  logic signed [2*PW-1:0] vm [6];
  logic                   vm_vld;
  vside_t                 vside_vm;
  pipe_ctl_t              ctl_vm;

  assign ctl_vm = '{en: en, vld: d_vld_r};

  for (genvar k = 0; k < 6; k++) begin : g_vm
    if (k == 0) begin : g_tag
      cpt_mul #(.AW(PW), .BW(PW), .TW($bits(vside_t))) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl_i(ctl_vm), .a_i(d_r[(k % 3) * 2]),
        .b_i(d_r[RHS_IDX[k]]), .tag_i(vside1), .vld_o(vm_vld), .prod_o(vm[k]),
        .tag_o(vside_vm)
      );
    end else begin : g_plain
      cpt_mul #(.AW(PW), .BW(PW), .TW(1)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl_i(ctl_vm), .a_i(d_r[(k % 3) * 2]),
        .b_i(d_r[RHS_IDX[k]]), .tag_i(1'b0), .vld_o(), .prod_o(vm[k]), .tag_o()
      );
    end
  end

  // Barycentric numerators vc, vb, va.
  logic                 v_vld_r;
  logic signed [VW-1:0] vc_r;
  logic signed [VW-1:0] vb_r;
  logic signed [VW-1:0] va_r;
  vside_t               vside_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
    end else if (en) begin
      v_vld_r <= vm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc_r      <= VW'(vm[0]) - VW'(vm[1]);
      vb_r      <= VW'(vm[2]) - VW'(vm[3]);
      va_r      <= VW'(vm[4]) - VW'(vm[5]);
      vside_v_r <= vside_vm;
    end
  end

  // Region decision and selection of the numerator factors, divisor and base point.
  logic signed [PW-1:0]  dv [6];
  logic signed [PW:0]    e43;
  logic signed [PW:0]    e56;
  logic signed [FW-1:0]  den_int;
  logic signed [FW-1:0]  den_e;
  logic signed [FW-1:0]  f_nxt;
  logic signed [FW-1:0]  g_nxt;
  logic signed [FW-1:0]  den_nxt;
  region_t               region_nxt;
  logic                  degen_nxt;
  base_sel_t             bsel;
  vec_sel_t              xsel;

  for (genvar j = 0; j < 6; j++) begin : g_dv
    assign dv[j] = vside_v_r.d[j];
  end

  assign e43     = (PW + 1)'(dv[3]) - (PW + 1)'(dv[2]);
  assign e56     = (PW + 1)'(dv[4]) - (PW + 1)'(dv[5]);
  assign den_int = FW'(va_r) + FW'(vb_r) + FW'(vc_r);

  always_comb begin
    region_nxt = REG_INT;
    degen_nxt  = 1'b0;
    f_nxt      = '0;
    g_nxt      = '0;
    den_nxt    = FW'(1);
    den_e      = '0;
    bsel       = BASE_A;
    xsel       = VEC_AB;
    if (dv[0] <= 0 && dv[1] <= 0) begin
      region_nxt = REG_A;
    end else if (dv[2] >= 0 && dv[3] <= dv[2]) begin
      region_nxt = REG_B;
      bsel       = BASE_B;
    end else if (dv[5] >= 0 && dv[4] <= dv[5]) begin
      region_nxt = REG_C;
      bsel       = BASE_C;
    end else if (vc_r <= 0 && dv[0] >= 0 && dv[2] <= 0) begin
      region_nxt = REG_AB;
      den_e      = FW'(dv[0]) - FW'(dv[2]);
      if (den_e != 0) begin
        f_nxt   = FW'(dv[0]);
        den_nxt = den_e;
      end
    end else if (vb_r <= 0 && dv[1] >= 0 && dv[5] <= 0) begin
      region_nxt = REG_AC;
      xsel       = VEC_AC;
      den_e      = FW'(dv[1]) - FW'(dv[5]);
      if (den_e != 0) begin
        f_nxt   = FW'(dv[1]);
        den_nxt = den_e;
      end
    end else if (va_r <= 0 && e43 >= 0 && e56 >= 0) begin
      region_nxt = REG_BC;
      bsel       = BASE_B;
      xsel       = VEC_BC;
      den_e      = FW'(e43) + FW'(e56);
      if (den_e != 0) begin
        f_nxt   = FW'(e43);
        den_nxt = den_e;
      end
    end else if (den_int <= 0) begin
      // Degenerate triangle: report A.
      degen_nxt = 1'b1;
    end else begin
      f_nxt   = FW'(vb_r);
      g_nxt   = FW'(vc_r);
      den_nxt = den_int;
    end
  end

  logic                  r_vld_r;
  logic signed [FW-1:0]  f_r;
  logic signed [FW-1:0]  g_r;
  logic signed [DFW-1:0] x_r [3];
  logic signed [DFW-1:0] y_r [3];
  nside_t                nside_r;
  nside_t                nside_nxt;
  logic signed [DFW-1:0] x_nxt [3];

  // Pick the base point and the edge vector for each coordinate.
  always_comb begin
    nside_nxt.den    = den_nxt;
    nside_nxt.region = region_nxt;
    nside_nxt.degen  = degen_nxt;
    for (int i = 0; i < 3; i++) begin
      case (bsel)
        BASE_B:  nside_nxt.base[i] = vside_v_r.side.b[i];
        BASE_C:  nside_nxt.base[i] = vside_v_r.side.c[i];
        default: nside_nxt.base[i] = vside_v_r.side.a[i];
      endcase
      case (xsel)
        VEC_AC:  x_nxt[i] = vside_v_r.side.ac[i];
        VEC_BC:  x_nxt[i] = vside_v_r.side.bc[i];
        default: x_nxt[i] = vside_v_r.side.ab[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (en) begin
      r_vld_r <= v_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r     <= f_nxt;
      g_r     <= g_nxt;
      nside_r <= nside_nxt;
      for (int i = 0; i < 3; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= vside_v_r.side.ac[i];
      end
    end
  end

  // Numerator per coordinate: X*F + Y*G.
  logic signed [FW+DFW-1:0] pf [3];
  logic signed [FW+DFW-1:0] pg [3];
  logic                     nm_vld;
  nside_t                   nside_nm;
  pipe_ctl_t                ctl_nm;

  assign ctl_nm = '{en: en, vld: r_vld_r};

  for (genvar i = 0; i < 3; i++) begin : g_nm
    if (i == 0) begin : g_tag
      cpt_mul #(.AW(FW), .BW(DFW), .TW($bits(nside_t))) u_mul_f (
        .clk(clk), .rst_n(rst_n), .ctl_i(ctl_nm), .a_i(f_r), .b_i(x_r[i]),
        .tag_i(nside_r), .vld_o(nm_vld), .prod_o(pf[i]), .tag_o(nside_nm)
      );
    end else begin : g_plain
      cpt_mul #(.AW(FW), .BW(DFW), .TW(1)) u_mul_f (
        .clk(clk), .rst_n(rst_n), .ctl_i(ctl_nm), .a_i(f_r), .b_i(x_r[i]),
        .tag_i(1'b0), .vld_o(), .prod_o(pf[i]), .tag_o()
      );
    end
    cpt_mul #(.AW(FW), .BW(DFW), .TW(1)) u_mul_g (
      .clk(clk), .rst_n(rst_n), .ctl_i(ctl_nm), .a_i(g_r), .b_i(y_r[i]),
      .tag_i(1'b0), .vld_o(), .prod_o(pg[i]), .tag_o()
    );
  end

  logic                  n_vld_r;
  logic signed [NMW-1:0] num_r [3];
  nside_t                nside_n_r;
  oside_t                oside_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else if (en) begin
      n_vld_r <= nm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= NMW'(pf[i]) + NMW'(pg[i]);
      end
      nside_n_r <= nside_nm;
    end
  end

  assign oside_n.base   = nside_n_r.base;
  assign oside_n.region = nside_n_r.region;
  assign oside_n.degen  = nside_n_r.degen;

  // Rounding division of each coordinate's numerator.
  logic signed [QB:0] quo [3];
  logic               dq_vld;
  oside_t             oside_q;
  pipe_ctl_t          ctl_dq;

  assign ctl_dq = '{en: en, vld: n_vld_r};

  for (genvar i = 0; i < 3; i++) begin : g_dq
    if (i == 0) begin : g_tag
      cpt_div #(.NW(NMW), .DW(FW), .QB(QB), .TW($bits(oside_t))) u_div (
        .clk(clk), .rst_n(rst_n), .ctl_i(ctl_dq), .num_i(num_r[i]),
        .den_i(nside_n_r.den), .tag_i(oside_n), .vld_o(dq_vld), .quo_o(quo[i]),
        .tag_o(oside_q)
      );
    end else begin : g_plain
      cpt_div #(.NW(NMW), .DW(FW), .QB(QB), .TW(1)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl_i(ctl_dq), .num_i(num_r[i]),
        .den_i(nside_n_r.den), .tag_i(1'b0), .vld_o(), .quo_o(quo[i]), .tag_o()
      );
    end
  end

  // Add the base point and saturate to the coordinate range.
  out_t res;

  assign res.region = oside_q.region;
  assign res.degen  = oside_q.degen;

  for (genvar i = 0; i < 3; i++) begin : g_res
    logic signed [SW-1:0] sum;
    logic signed [CB-1:0] base_s;
    logic                 ovf;
    assign base_s      = oside_q.base[i];
    assign sum         = SW'(base_s) + SW'(quo[i]);
    assign ovf         = (sum[SW-1:CB-1] != {(SW - CB + 1){sum[SW-1]}});
    assign res.near[i] = ovf ? {sum[SW-1], {(CB - 1){~sum[SW-1]}}} : sum[CB-1:0];
  end

  // Output buffer; its free space drives the pipeline enable.
  logic push;
  out_t ob_data;

  assign push = dq_vld && en;

  cpt_obuf #(.DW($bits(out_t))) u_obuf (
    .clk(clk), .rst_n(rst_n), .push_i(push), .data_i(res), .ready_o(en),
    .valid_o(out_chan.valid), .pop_i(out_chan.ready), .data_o(ob_data)
  );

  assign out_chan.near_x     = ob_data.near[0];
  assign out_chan.near_y     = ob_data.near[1];
  assign out_chan.near_z     = ob_data.near[2];
  assign out_chan.region     = ob_data.region;
  assign out_chan.degenerate = ob_data.degen;

  // The input side only stalls while results are waiting at the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no result waiting");

  // A degenerate result is always reported as an interior result.
  a_degen_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.degenerate |-> out_chan.region == REG_INT)
    else $error("degenerate flag outside the interior region");

  // Vertex regions must leave a zero offset over a unit divisor.
  a_vertex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    r_vld_r && (nside_r.region == REG_A || nside_r.region == REG_B ||
                nside_r.region == REG_C)
    |-> (f_r == 0) && (g_r == 0) && (nside_r.den == FW'(1)))
    else $error("vertex region with non-zero offset terms");

endmodule
